[hw/rtl/qmop_pkg.sv]
// Shared types and constants for the quadratic map orbit plotter.
package qmop_pkg;

    localparam int COORD_BITS   = 32;
    localparam int FRAC_BITS    = 28;
    localparam int PROD_BITS    = 2 * COORD_BITS;
    localparam int SCALE_FRAC   = 16;
    localparam int PIX_SHIFT    = FRAC_BITS + SCALE_FRAC;
    localparam int PIX_BITS     = 12;
    localparam int FRAME_BITS   = 13;
    localparam int LIMIT_BITS   = PROD_BITS - PIX_SHIFT;
    localparam int AREA_BITS    = 2 * FRAME_BITS;
    localparam int CFG_BITS     = 32;
    localparam int CFG_IDX_BITS = 3;
    localparam int ITER_BITS    = 24;
    localparam int DRAWN_BITS   = 23;

    // Orbit start point, 0.1 rounded to the nearest fixed-point step.
    localparam logic signed [COORD_BITS-1:0] START_FIX =
        COORD_BITS'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);

    localparam logic [CFG_BITS-1:0]   RST_COEF_A    = 32'd375809638;
    localparam logic [CFG_BITS-1:0]   RST_COEF_B    = 32'd80530637;
    localparam logic [CFG_BITS-1:0]   RST_VIEW_LEFT = 32'hE8000000;
    localparam logic [CFG_BITS-1:0]   RST_VIEW_TOP  = 32'd107374182;
    localparam logic [CFG_BITS-1:0]   RST_X_SCALE   = 32'd22369621;
    localparam logic [CFG_BITS-1:0]   RST_Y_SCALE   = 32'd62914560;
    localparam logic [FRAME_BITS-1:0] RST_FRAME_W   = 13'd1024;
    localparam logic [FRAME_BITS-1:0] RST_FRAME_H   = 13'd768;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_COEF_A,
        CFG_COEF_B,
        CFG_VIEW_LEFT,
        CFG_VIEW_TOP,
        CFG_X_SCALE,
        CFG_Y_SCALE,
        CFG_FRAME_W,
        CFG_FRAME_H
    } qmop_cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AXX,
        ST_NX,
        ST_SCALE,
        ST_EMIT
    } qmop_state_t;

    typedef enum logic [1:0] {
        RES_ZERO,
        RES_HELD,
        RES_STEP
    } qmop_res_mode_t;

    typedef struct packed {
        logic           restart;
        logic           start_step;
        logic           sat_mul;
        logic           update;
        logic           scale;
        logic           emit;
        qmop_res_mode_t mode;
    } qmop_cmd_t;

    typedef struct packed {
        logic done_flag;
        logic out_free;
    } qmop_status_t;

endpackage

[hw/rtl/qmop_datapath.sv]
// Datapath: configuration registers, orbit state, multipliers, counters and output word.
module qmop_datapath
    import qmop_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  qmop_cmd_t               cmd,
    output qmop_status_t            status,
    input  logic [ITER_BITS-1:0]    skip_count,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data,
    input  logic                    out_ready,
    output logic                    out_valid,
    output logic [PIX_BITS-1:0]     pixel_x,
    output logic [PIX_BITS-1:0]     pixel_y,
    output logic                    plot,
    output logic                    budget_done,
    output logic                    diverged
);

    localparam logic signed [PROD_BITS-1:0] WIDE_MAX =
        (PROD_BITS'(1) << (COORD_BITS - 1)) - PROD_BITS'(1);
    localparam logic signed [PROD_BITS-1:0] WIDE_MIN = -WIDE_MAX - PROD_BITS'(1);
    localparam logic signed [PROD_BITS-1:0] ONE_WIDE = PROD_BITS'(1) << FRAC_BITS;

    function automatic logic signed [PROD_BITS-1:0] smul(
        input logic signed [COORD_BITS:0] a,
        input logic signed [COORD_BITS:0] b
    );
        logic signed [2*COORD_BITS+1:0] full;
        full = a * b;
        return full[PROD_BITS-1:0];
    endfunction

    function automatic logic ovf(input logic signed [PROD_BITS-1:0] v);
        return (v > WIDE_MAX) || (v < WIDE_MIN);
    endfunction

    function automatic logic signed [COORD_BITS-1:0] sat(
        input logic signed [PROD_BITS-1:0] v
    );
        logic signed [COORD_BITS-1:0] r;
        r = v[COORD_BITS-1:0];
        if (v > WIDE_MAX)
        begin
            r = WIDE_MAX[COORD_BITS-1:0];
        end
        else if (v < WIDE_MIN)
        begin
            r = WIDE_MIN[COORD_BITS-1:0];
        end
        return r;
    endfunction

    // Configuration registers.
    logic [CFG_BITS-1:0]   coef_a_reg, coef_b_reg, view_left_reg, view_top_reg;
    logic [CFG_BITS-1:0]   x_scale_reg, y_scale_reg;
    logic [FRAME_BITS-1:0] frame_w_reg, frame_h_reg;

    // Orbit and counter state.
    logic signed [COORD_BITS-1:0] orbit_x_reg, orbit_y_reg;
    logic [ITER_BITS-1:0]         iter_reg, skip_reg;
    logic [DRAWN_BITS-1:0]        drawn_reg;
    logic                         done_flag_reg;

    // Working registers of one step.
    logic signed [PROD_BITS-1:0]  p0_reg, p1_reg;
    logic signed [COORD_BITS-1:0] ny_reg;
    logic signed [COORD_BITS:0]   dx_reg, dy_reg;
    logic                         div_reg, over_reg, skipped_reg;

    // Output word.
    logic                  out_valid_reg;
    logic [PIX_BITS-1:0]   pixel_x_reg, pixel_y_reg;
    logic                  plot_reg, budget_done_reg, diverged_reg;

    logic signed [COORD_BITS:0]   ma0, mb0, ma1, mb1;
    logic signed [PROD_BITS-1:0]  sh0, sh1, y_wide, nx_sum;
    logic signed [COORD_BITS-1:0] xx_sat, nx;
    logic [AREA_BITS-1:0]         area, quad_drawn;
    logic                         dx_pos, dy_pos, fx_in, fy_in, hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_a_reg    <= RST_COEF_A;
            coef_b_reg    <= RST_COEF_B;
            view_left_reg <= RST_VIEW_LEFT;
            view_top_reg  <= RST_VIEW_TOP;
            x_scale_reg   <= RST_X_SCALE;
            y_scale_reg   <= RST_Y_SCALE;
            frame_w_reg   <= RST_FRAME_W;
            frame_h_reg   <= RST_FRAME_H;
        end
        else if (cfg_we)
        begin
            unique case (qmop_cfg_idx_t'(cfg_index))
                CFG_COEF_A:    coef_a_reg    <= cfg_data;
                CFG_COEF_B:    coef_b_reg    <= cfg_data;
                CFG_VIEW_LEFT: view_left_reg <= cfg_data;
                CFG_VIEW_TOP:  view_top_reg  <= cfg_data;
                CFG_X_SCALE:   x_scale_reg   <= cfg_data;
                CFG_Y_SCALE:   y_scale_reg   <= cfg_data;
                CFG_FRAME_W:   frame_w_reg   <= cfg_data[FRAME_BITS-1:0];
                CFG_FRAME_H:   frame_h_reg   <= cfg_data[FRAME_BITS-1:0];
                default:       frame_h_reg   <= frame_h_reg;
            endcase
        end
    end

    assign sh0    = p0_reg >>> FRAC_BITS;
    assign sh1    = p1_reg >>> FRAC_BITS;
    assign xx_sat = sat(sh0);
    assign y_wide = {{(PROD_BITS-COORD_BITS){orbit_y_reg[COORD_BITS-1]}}, orbit_y_reg};
    assign nx_sum = ONE_WIDE - sh0 + y_wide;
    assign nx     = sat(nx_sum);

    assign area       = AREA_BITS'(frame_w_reg) * AREA_BITS'(frame_h_reg);
    assign quad_drawn = AREA_BITS'({drawn_reg, 2'b00});

    // Operand selection for the two shared multipliers.
    always_comb
    begin
        ma0 = '0;
        mb0 = '0;
        ma1 = '0;
        mb1 = '0;
        priority if (cmd.start_step)
        begin
            ma0 = {orbit_x_reg[COORD_BITS-1], orbit_x_reg};
            mb0 = {orbit_x_reg[COORD_BITS-1], orbit_x_reg};
            ma1 = {coef_b_reg[COORD_BITS-1], coef_b_reg};
            mb1 = {orbit_x_reg[COORD_BITS-1], orbit_x_reg};
        end
        else if (cmd.sat_mul)
        begin
            ma0 = {coef_a_reg[COORD_BITS-1], coef_a_reg};
            mb0 = {xx_sat[COORD_BITS-1], xx_sat};
        end
        else if (cmd.scale)
        begin
            ma0 = {1'b0, dx_reg[COORD_BITS-1:0]};
            mb0 = {1'b0, x_scale_reg};
            ma1 = {1'b0, dy_reg[COORD_BITS-1:0]};
            mb1 = {1'b0, y_scale_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start_step || cmd.sat_mul || cmd.scale)
        begin
            p0_reg <= smul(ma0, mb0);
        end
        if (cmd.start_step || cmd.scale)
        begin
            p1_reg <= smul(ma1, mb1);
        end
        if (cmd.sat_mul)
        begin
            ny_reg  <= sat(sh1);
            div_reg <= ovf(sh0) || ovf(sh1);
        end
        if (cmd.update)
        begin
            div_reg  <= div_reg || ovf(nx_sum);
            dx_reg   <= {nx[COORD_BITS-1], nx}
                        - {view_left_reg[COORD_BITS-1], view_left_reg};
            dy_reg   <= {view_top_reg[COORD_BITS-1], view_top_reg}
                        - {ny_reg[COORD_BITS-1], ny_reg};
            over_reg    <= quad_drawn > area;
            skipped_reg <= iter_reg < skip_reg;
        end
    end

    assign dx_pos = !dx_reg[COORD_BITS] && (dx_reg != '0);
    assign dy_pos = !dy_reg[COORD_BITS] && (dy_reg != '0);
    assign fx_in  = p0_reg[PROD_BITS-1:PIX_SHIFT] < LIMIT_BITS'(frame_w_reg);
    assign fy_in  = p1_reg[PROD_BITS-1:PIX_SHIFT] < LIMIT_BITS'(frame_h_reg);
    assign hit    = !over_reg && !skipped_reg && dx_pos && dy_pos && fx_in && fy_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            orbit_x_reg   <= START_FIX;
            orbit_y_reg   <= START_FIX;
            iter_reg      <= '0;
            skip_reg      <= '0;
            drawn_reg     <= '0;
            done_flag_reg <= 1'b0;
        end
        else if (cmd.restart)
        begin
            orbit_x_reg   <= START_FIX;
            orbit_y_reg   <= START_FIX;
            iter_reg      <= '0;
            skip_reg      <= skip_count;
            drawn_reg     <= '0;
            done_flag_reg <= 1'b0;
        end
        else if (cmd.update)
        begin
            orbit_x_reg <= nx;
            orbit_y_reg <= ny_reg;
            if (quad_drawn > area)
            begin
                done_flag_reg <= 1'b1;
            end
            else if (iter_reg != '1)
            begin
                iter_reg <= iter_reg + ITER_BITS'(1);
            end
        end
        else if (cmd.emit && cmd.mode == RES_STEP && hit && drawn_reg != '1)
        begin
            drawn_reg <= drawn_reg + DRAWN_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            unique case (cmd.mode)
                RES_STEP:
                begin
                    pixel_x_reg     <= hit ? p0_reg[PIX_SHIFT +: PIX_BITS] : '0;
                    pixel_y_reg     <= hit ? p1_reg[PIX_SHIFT +: PIX_BITS] : '0;
                    plot_reg        <= hit;
                    budget_done_reg <= done_flag_reg;
                    diverged_reg    <= div_reg;
                end
                RES_HELD:
                begin
                    pixel_x_reg     <= '0;
                    pixel_y_reg     <= '0;
                    plot_reg        <= 1'b0;
                    budget_done_reg <= 1'b1;
                    diverged_reg    <= 1'b0;
                end
                default:
                begin
                    pixel_x_reg     <= '0;
                    pixel_y_reg     <= '0;
                    plot_reg        <= 1'b0;
                    budget_done_reg <= 1'b0;
                    diverged_reg    <= 1'b0;
                end
            endcase
        end
    end

    assign status.done_flag = done_flag_reg;
    assign status.out_free  = !out_valid_reg || out_ready;

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign plot        = plot_reg;
    assign budget_done = budget_done_reg;
    assign diverged    = diverged_reg;

`ifndef SYNTHESIS
    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (done_flag_reg && !cmd.restart) |=> done_flag_reg)
        else $error("done flag cleared without a restart");

    a_plot_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && plot_reg) |-> !budget_done_reg)
        else $error("point plotted in a word that reports the budget spent");

    a_idle_pixels_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !plot_reg) |-> (pixel_x_reg == '0 && pixel_y_reg == '0))
        else $error("pixel coordinates not zero on a word without a plot");
`endif

endmodule

[hw/rtl/qmop_ctrl.sv]
// Controller: sequences one orbit step through the shared multipliers, and restart and held words.
module qmop_ctrl
    import qmop_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic         kind,
    input  qmop_status_t status,
    output qmop_cmd_t    cmd
);

    qmop_state_t    state_reg, state_next;
    qmop_res_mode_t mode_reg, mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= RES_ZERO;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.mode   = mode_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    priority if (kind)
                    begin
                        cmd.restart = 1'b1;
                        mode_next   = RES_ZERO;
                        state_next  = ST_EMIT;
                    end
                    else if (status.done_flag)
                    begin
                        mode_next  = RES_HELD;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        cmd.start_step = 1'b1;
                        mode_next      = RES_STEP;
                        state_next     = ST_AXX;
                    end
                end
            end
            ST_AXX:
            begin
                cmd.sat_mul = 1'b1;
                state_next  = ST_NX;
            end
            ST_NX:
            begin
                cmd.update = 1'b1;
                state_next = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // The word waits here while the previous one is still held.
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef SYNTHESIS
    a_step_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && !kind && !status.done_flag)
        |-> ##4 (state_reg == ST_EMIT))
        else $error("orbit step did not reach the emit state in four cycles");

    a_short_items: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && in_valid && (kind || status.done_flag))
        |=> (state_reg == ST_EMIT))
        else $error("restart or frozen item did not go straight to emit");

    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> status.out_free)
        else $error("word emitted over an output word not yet taken");
`endif

endmodule

[hw/rtl/quadratic_map_orbit_plotter_top.sv]
// Top level of the quadratic map orbit plotter: controller and datapath.
//
// Input words (in_valid/in_ready) carry kind and skip_count. kind 0 advances
// the orbit one step; kind 1 restarts the orbit at (0.1, 0.1), clears the
// counters and loads skip_count. Every input word gives exactly one output
// word (out_valid/out_ready) with pixel_x, pixel_y, plot, budget_done and
// diverged.
// An orbit step goes from the edge that accepts it through the
// saturate-and-multiply for a*x*x, the new point and view offsets, the
// scale multiplies and the emit cycle, in that order, to the output
// register; the chain of dependent 33 by 33 bit multiplies is why a step
// is split this way. A restart word, or a step once the budget is spent,
// goes from its acceptance straight to the emit cycle. A new word is taken
// in the cycle after the previous one has reached the output register.
// If the receiver stalls, the finished word waits in the output register
// and the next step waits in its emit cycle until the register is free.
// Reset sets every configuration register to its default and the orbit to
// its start point; there is no clearing pass. Configuration writes take
// effect at once and are meant for when no word is in flight.
module quadratic_map_orbit_plotter_top
    import qmop_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic                    kind,
    input  logic [ITER_BITS-1:0]    skip_count,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [PIX_BITS-1:0]     pixel_x,
    output logic [PIX_BITS-1:0]     pixel_y,
    output logic                    plot,
    output logic                    budget_done,
    output logic                    diverged,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [CFG_BITS-1:0]     cfg_data
);

    qmop_cmd_t    cmd;
    qmop_status_t status;

    qmop_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .kind     (kind),
        .status   (status),
        .cmd      (cmd)
    );

    qmop_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .skip_count  (skip_count),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .plot        (plot),
        .budget_done (budget_done),
        .diverged    (diverged)
    );

endmodule
